// ===== rtl/azps_pkg.sv =====
// Shared types and constants for the azimuth position servo.
// Used by azps_div and azimuth_position_servo; depends on nothing else.
package azps_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PGAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DGAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IGAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOFTEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FULLSCL  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MANUAL   = 3'd6;

  localparam logic [1:0] MODE_DIRECT   = 2'd0;
  localparam logic [1:0] MODE_POSITION = 2'd1;

  // Shared multiplier: signed operands, product kept at full width
  localparam int MUL_W  = 29;
  localparam int PROD_W = 2 * MUL_W;

  // Shared divider: signed dividend, positive divisor, one quotient bit a cycle
  localparam int DIV_NUM_W = 44;
  localparam int DIV_DEN_W = 40;
  localparam int DIV_STEPS = DIV_NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Drive value after the PID sum, Q.16
  localparam int DRIVE_W = 43;

  localparam logic signed [MUL_W-1:0] TWO_PI_Q16  = 29'sd411775;
  localparam logic signed [MUL_W-1:0] MS_PER_S    = 29'sd1000;
  localparam logic [DRIVE_W-1:0]      DEADBAND_Q16 = 43'd6553;
  localparam logic [DRIVE_W-1:0]      CAP_Q16      = 43'd64881;
  localparam logic signed [15:0]      NEAR_COUNTS  = 16'sd910;

endpackage

// ===== rtl/azimuth_position_servo.sv =====
// Azimuth position servo: one PID step per control tick, bearings in, PWM count out.
// Depends on azps_pkg and instantiates the shared divider azps_div.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    current_bearing, target_bearing, now_ms
//   out      out_valid / out_stall  pwm_count, clockwise, velocity_estimate
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One shared multiplier and one 44-step restoring divider work under a sequencer.
// A position-loop beat runs the divider twice when the velocity is re-estimated and
// the integral grows, once when only one of these happens, and not at all otherwise;
// direct and idle beats skip the loop and go straight to shaping.
// in_stall is high from acceptance until the result is loaded into the output register.
// A held output only delays that load. rst is synchronous; cfg_ready is always high.
module azimuth_position_servo (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [15:0]                    current_bearing,
  input  logic        [15:0]                    target_bearing,
  input  logic        [31:0]                    now_ms,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [15:0]                    pwm_count,
  output logic                                  clockwise,
  output logic signed [27:0]                    velocity_estimate,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [azps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [azps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import azps_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_ERR_MUL  = 5'd1;
  localparam logic [4:0] S_ERR_RAD  = 5'd2;
  localparam logic [4:0] S_DR_MUL   = 5'd3;
  localparam logic [4:0] S_DR_RAD   = 5'd4;
  localparam logic [4:0] S_VEL_MUL  = 5'd5;
  localparam logic [4:0] S_VEL_DIV  = 5'd6;
  localparam logic [4:0] S_VEL_WAIT = 5'd7;
  localparam logic [4:0] S_NEAR     = 5'd8;
  localparam logic [4:0] S_SQ_MUL   = 5'd9;
  localparam logic [4:0] S_DEN      = 5'd10;
  localparam logic [4:0] S_IG_MUL   = 5'd11;
  localparam logic [4:0] S_INT_DIV  = 5'd12;
  localparam logic [4:0] S_INT_WAIT = 5'd13;
  localparam logic [4:0] S_P_MUL    = 5'd14;
  localparam logic [4:0] S_D_MUL    = 5'd15;
  localparam logic [4:0] S_DRV      = 5'd16;
  localparam logic [4:0] S_SHAPE    = 5'd17;
  localparam logic [4:0] S_SCALE    = 5'd18;
  localparam logic [4:0] S_LOAD     = 5'd19;

  // Configuration registers
  logic        [23:0] proportional_gain;
  logic        [23:0] derivative_gain;
  logic        [23:0] integral_gain;
  logic        [23:0] integral_softening;
  logic        [1:0]  drive_mode;
  logic        [15:0] full_scale_count;
  logic signed [17:0] manual_drive;

  // Loop state
  logic        [15:0] previous_bearing;
  logic        [31:0] previous_time;
  logic signed [27:0] previous_velocity;
  logic signed [31:0] integral_term;

  // Working registers of one beat
  logic        [4:0]         state;
  logic        [15:0]        cur;
  logic        [31:0]        now_q;
  logic signed [15:0]        err_counts;
  logic signed [15:0]        dr_counts;
  logic        [31:0]        dt;
  logic signed [18:0]        err;
  logic signed [18:0]        dr;
  logic signed [27:0]        vel;
  logic        [DIV_DEN_W-1:0] den;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  acc;
  logic signed [DRIVE_W-1:0] drive;
  logic        [15:0]        mag;
  logic                      cw;

  // Datapath
  logic signed [MUL_W-1:0]     mul_a;
  logic signed [MUL_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]    prod_rnd;
  logic signed [18:0]          rad;
  logic                        div_start;
  logic signed [DIV_NUM_W-1:0] div_num;
  logic        [DIV_DEN_W-1:0] div_den;
  logic                        div_done;
  logic signed [DIV_NUM_W-1:0] div_q;
  logic signed [27:0]          vel_sat;
  logic signed [DIV_NUM_W:0]   inc;
  logic signed [DIV_NUM_W:0]   int_sum;
  logic signed [31:0]          int_sat;
  logic        [DIV_DEN_W-1:0] den_sum;
  logic signed [PROD_W-1:0]    diff;
  logic signed [DRIVE_W-1:0]   drive_sum;
  logic        [DRIVE_W-1:0]   drive_abs;
  logic signed [15:0]          wrap_err;
  logic signed [15:0]          wrap_dr;
  logic                        load_out;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign load_out  = (state == S_LOAD) && (!out_valid || !out_stall);

  // Bearing differences wrap modulo a turn; half a turn reads as -pi.
  assign wrap_err = $signed(target_bearing - current_bearing);
  assign wrap_dr  = $signed(current_bearing - previous_bearing);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_ERR_MUL: begin
        mul_a = MUL_W'(err_counts);
        mul_b = TWO_PI_Q16;
      end
      S_DR_MUL: begin
        mul_a = MUL_W'(dr_counts);
        mul_b = TWO_PI_Q16;
      end
      S_VEL_MUL: begin
        mul_a = MUL_W'(dr);
        mul_b = MS_PER_S;
      end
      S_SQ_MUL: begin
        mul_a = MUL_W'(vel);
        mul_b = MUL_W'(vel);
      end
      S_IG_MUL: begin
        mul_a = $signed({5'd0, integral_gain});
        mul_b = MUL_W'(err);
      end
      S_P_MUL: begin
        mul_a = $signed({5'd0, proportional_gain});
        mul_b = MUL_W'(err);
      end
      S_D_MUL: begin
        mul_a = $signed({5'd0, derivative_gain});
        mul_b = MUL_W'(vel);
      end
      // The scaled count is held while the output register is still occupied.
      S_SCALE, S_LOAD: begin
        mul_a = $signed({13'd0, mag});
        mul_b = $signed({13'd0, full_scale_count});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Counts to Q.16 radians, rounded then floored.
  assign prod_rnd = prod + PROD_W'(32768);
  assign rad      = prod_rnd[34:16];

  assign div_start = (state == S_VEL_DIV) || (state == S_INT_DIV);
  assign div_num   = prod[DIV_NUM_W-1:0];
  assign div_den   = (state == S_VEL_DIV) ? {{(DIV_DEN_W-32){1'b0}}, dt} : den;

  azps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (div_q > DIV_NUM_W'(134217727)) begin
      vel_sat = 28'sh7FFFFFF;
    end else if (div_q < -$signed(DIV_NUM_W'(134217728))) begin
      vel_sat = $signed(28'h8000000);
    end else begin
      vel_sat = div_q[27:0];
    end
  end

  // The increment takes the sign of the velocity as well as that of the error.
  assign inc     = vel[27] ? -$signed({div_q[DIV_NUM_W-1], div_q})
                           : $signed({div_q[DIV_NUM_W-1], div_q});
  assign int_sum = (DIV_NUM_W+1)'(integral_term) + inc;

  always_comb begin
    if (int_sum > (DIV_NUM_W+1)'(32'sh7FFFFFFF)) begin
      int_sat = 32'sh7FFFFFFF;
    end else if (int_sum < (DIV_NUM_W+1)'($signed(32'h80000000))) begin
      int_sat = $signed(32'h80000000);
    end else begin
      int_sat = int_sum[31:0];
    end
  end

  // Velocity squared is never negative, so the floor shift is a plain slice.
  assign den_sum = prod[DIV_DEN_W+15:16] + {{(DIV_DEN_W-24){1'b0}}, integral_softening};

  assign diff      = acc - prod;
  assign drive_sum = DRIVE_W'(diff >>> 16) + DRIVE_W'(integral_term);
  assign drive_abs = drive[DRIVE_W-1] ? DRIVE_W'(-drive) : DRIVE_W'(drive);

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      proportional_gain  <= 24'd163840;
      derivative_gain    <= 24'd14418;
      integral_gain      <= 24'd19661;
      integral_softening <= 24'd65536;
      drive_mode         <= MODE_DIRECT;
      full_scale_count   <= 16'd19000;
      manual_drive       <= '0;
      previous_bearing   <= '0;
      previous_time      <= '0;
      previous_velocity  <= '0;
      integral_term      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PGAIN:   proportional_gain  <= cfg_data;
          REG_DGAIN:   derivative_gain    <= cfg_data;
          REG_IGAIN:   integral_gain      <= cfg_data;
          REG_SOFTEN:  integral_softening <= cfg_data;
          REG_MODE:    drive_mode         <= cfg_data[1:0];
          REG_FULLSCL: full_scale_count   <= cfg_data[15:0];
          REG_MANUAL:  manual_drive       <= $signed(cfg_data[17:0]);
          default:     ;
        endcase
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (drive_mode == MODE_POSITION) begin
              state <= S_ERR_MUL;
            end else begin
              state <= S_SHAPE;
            end
          end
        end
        S_ERR_MUL: state <= S_ERR_RAD;
        S_ERR_RAD: state <= (dt != '0) ? S_DR_MUL : S_NEAR;
        S_DR_MUL:  state <= S_DR_RAD;
        S_DR_RAD:  state <= S_VEL_MUL;
        S_VEL_MUL: state <= S_VEL_DIV;
        S_VEL_DIV: state <= S_VEL_WAIT;
        S_VEL_WAIT: begin
          if (div_done) begin
            previous_bearing  <= cur;
            previous_time     <= now_q;
            previous_velocity <= vel_sat;
            state             <= S_NEAR;
          end
        end
        S_NEAR: begin
          if (err_counts <= NEAR_COUNTS && err_counts >= -NEAR_COUNTS) begin
            state <= S_SQ_MUL;
          end else begin
            integral_term <= '0;
            state         <= S_P_MUL;
          end
        end
        S_SQ_MUL:  state <= S_DEN;
        S_DEN:     state <= S_IG_MUL;
        S_IG_MUL:  state <= S_INT_DIV;
        S_INT_DIV: state <= S_INT_WAIT;
        S_INT_WAIT: begin
          if (div_done) begin
            integral_term <= int_sat;
            state         <= S_P_MUL;
          end
        end
        S_P_MUL: state <= S_D_MUL;
        S_D_MUL: state <= S_DRV;
        S_DRV:   state <= S_SHAPE;
        S_SHAPE: state <= S_SCALE;
        S_SCALE: state <= S_LOAD;
        S_LOAD: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers of the beat in progress and of the output stage.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        cur        <= current_bearing;
        now_q      <= now_ms;
        err_counts <= wrap_err;
        dr_counts  <= wrap_dr;
        dt         <= now_ms - previous_time;
        vel        <= previous_velocity;
        if (drive_mode == MODE_DIRECT) begin
          drive <= DRIVE_W'(manual_drive);
        end else begin
          drive <= '0;
        end
      end
      S_ERR_RAD: err <= rad;
      S_DR_RAD:  dr  <= rad;
      S_VEL_WAIT: begin
        if (div_done) begin
          vel <= vel_sat;
        end
      end
      S_DEN: den <= (den_sum == '0) ? DIV_DEN_W'(1) : den_sum;
      S_D_MUL: acc <= prod;
      S_DRV:   drive <= drive_sum;
      S_SHAPE: begin
        // Inside the deadband the count is zero and the direction reads clockwise.
        if (drive_abs <= DEADBAND_Q16) begin
          mag <= '0;
          cw  <= 1'b1;
        end else begin
          mag <= (drive_abs > CAP_Q16) ? CAP_Q16[15:0] : drive_abs[15:0];
          cw  <= !drive[DRIVE_W-1];
        end
      end
      default: ;
    endcase
    if (load_out) begin
      pwm_count         <= prod[31:16];
      clockwise         <= cw;
      velocity_estimate <= vel;
    end
  end

endmodule

// ===== rtl/azps_div.sv =====
// Restoring divider shared by the velocity and integral steps of the servo.
// Signed dividend, positive divisor, quotient truncated toward zero.
// Depends on azps_pkg for its widths.
module azps_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [azps_pkg::DIV_NUM_W-1:0] dividend,
  input  logic        [azps_pkg::DIV_DEN_W-1:0] divisor,
  output logic                                 done,
  output logic signed [azps_pkg::DIV_NUM_W-1:0] quotient
);
  import azps_pkg::*;

  logic [DIV_NUM_W-1:0] num;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 neg;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W+1:0] trial;
  logic                 fits;
  logic [DIV_NUM_W-1:0] dividend_mag;

  assign dividend_mag = dividend[DIV_NUM_W-1] ? DIV_NUM_W'(-dividend) : DIV_NUM_W'(dividend);
  assign shifted      = {rem, num[DIV_NUM_W-1]};
  assign trial        = {1'b0, shifted} - {2'b00, dvs};
  assign fits         = !trial[DIV_DEN_W+1];
  assign quotient     = neg ? -$signed(num) : $signed(num);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == DIV_CNT_W'(1));
      if (start) begin
        cnt <= DIV_CNT_W'(DIV_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - DIV_CNT_W'(1);
      end
    end
  end

  // The dividend register shifts out from the top while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend_mag;
      rem <= '0;
      dvs <= divisor;
      neg <= dividend[DIV_NUM_W-1];
    end else if (cnt != '0) begin
      rem <= fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
      num <= {num[DIV_NUM_W-2:0], fits};
    end
  end

endmodule

// ===== tb/azimuth_position_servo_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for azimuth_position_servo: directed and random bearing beats
// checked against a cycle-free predictor of the PID step. Depends on azps_pkg and the RTL.
module azimuth_position_servo_tb;
  import azps_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd2;
  localparam longint RAD_PER_TURN = 411775;
  localparam longint DEADBAND = 6553;
  localparam longint DRIVE_CAP = 64881;
  localparam int NEAR_COUNT = 910;
  localparam longint VEL_HI = 134217727;
  localparam longint VEL_LO = -134217728;
  localparam longint INTEG_HI = 2147483647;
  localparam longint INTEG_LO = -64'sd2147483648;
  localparam longint GAIN_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [15:0] current;
    logic [15:0] target;
    logic [31:0] stamp;
  } bearing_beat_t;

  typedef struct packed {
    logic [15:0] pwm;
    logic        cw;
    logic [27:0] vel;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] current_bearing = '0;
  logic [15:0] target_bearing = '0;
  logic [31:0] now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] pwm_count;
  logic clockwise;
  logic signed [27:0] velocity_estimate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  azimuth_position_servo dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .current_bearing(current_bearing), .target_bearing(target_bearing), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .pwm_count(pwm_count), .clockwise(clockwise), .velocity_estimate(velocity_estimate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Predictor copy of the registers, reset values included.
  longint p_gain = 163840;
  longint d_gain = 14418;
  longint i_gain = 19661;
  longint soften = 65536;
  logic [1:0] servo_mode = MODE_DIRECT;
  longint full_scale = 19000;
  longint manual_drive = 0;

  // Predictor copy of the loop state.
  logic [15:0] last_bearing = '0;
  logic [31:0] last_time = '0;
  longint last_vel = 0;
  longint integ = 0;

  bearing_beat_t beats_to_send[$];
  drive_result_t drive_due_q[$];
  int mismatches = 0;
  logic [31:0] stamp_ms = '0;
  logic [15:0] track_bearing = '0;
  int send_gap = 0;
  int send_quiet = 0;
  int hold_left = 0;
  int hold_quiet = 0;

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Shortest signed distance a - b in counts; a half turn comes out negative.
  function automatic int wrap_counts(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return int'($signed(d));
  endfunction

  function automatic longint counts_to_rad(int d);
    return (longint'(d) * RAD_PER_TURN + 32768) >>> 16;
  endfunction

  function automatic drive_result_t scale_drive(longint drive);
    drive_result_t r;
    longint mag, scaled;
    r = '0;
    r.cw = 1'b1;
    mag = (drive < 0) ? -drive : drive;
    if (mag > DEADBAND) begin
      if (mag > DRIVE_CAP) mag = DRIVE_CAP;
      scaled = mag * full_scale;
      r.pwm = scaled[31:16];
      r.cw = (drive >= 0);
    end
    return r;
  endfunction

  function automatic drive_result_t predict_drive(bearing_beat_t b);
    drive_result_t r;
    longint vel, err, dr, den, inc, span;
    int err_counts;
    logic [31:0] dt;
    vel = last_vel;
    r = '0;
    r.cw = 1'b1;
    if (servo_mode == MODE_DIRECT) begin
      r = scale_drive(manual_drive);
    end else if (servo_mode == MODE_POSITION) begin
      err_counts = wrap_counts(b.target, b.current);
      err = counts_to_rad(err_counts);
      dt = b.stamp - last_time;
      // Less than a millisecond elapsed: keep the old velocity and history.
      if (dt != 32'd0) begin
        span = longint'(dt);
        dr = counts_to_rad(wrap_counts(b.current, last_bearing));
        vel = clamp64(dr * 1000 / span, VEL_LO, VEL_HI);
        last_bearing = b.current;
        last_time = b.stamp;
        last_vel = vel;
      end
      if (err_counts <= NEAR_COUNT && err_counts >= -NEAR_COUNT) begin
        den = ((vel * vel) >>> 16) + soften;
        if (den == 0) den = 1;
        inc = i_gain * err / den;
        if (vel < 0) inc = -inc;
        integ = clamp64(integ + inc, INTEG_LO, INTEG_HI);
      end else begin
        integ = 0;
      end
      r = scale_drive(((p_gain * err - d_gain * vel) >>> 16) + integ);
    end
    r.vel = vel[27:0];
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    logic signed [17:0] m;
    m = val[17:0];
    case (idx)
      REG_PGAIN:   p_gain = longint'(val);
      REG_DGAIN:   d_gain = longint'(val);
      REG_IGAIN:   i_gain = longint'(val);
      REG_SOFTEN:  soften = longint'(val);
      REG_MODE:    servo_mode = val[1:0];
      REG_FULLSCL: full_scale = longint'(val[15:0]);
      REG_MANUAL:  manual_drive = longint'(m);
      default: ;
    endcase
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none at all.
  function automatic int pick_gap(inout int quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if (r < 4) quiet = $urandom_range(10, 40);
    if (r < 40) return 0;
    if (r < 88) return $urandom_range(1, 4);
    return $urandom_range(20, 160);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: %s", $time, msg);
  endtask

  // Sender: a beat leaves the queue only when the previous one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        drive_due_q.push_back(predict_drive({current_bearing, target_bearing, now_ms}));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (beats_to_send.size() > 0) begin
          bearing_beat_t b;
          b = beats_to_send.pop_front();
          current_bearing <= b.current;
          target_bearing <= b.target;
          now_ms <= b.stamp;
          in_valid <= 1'b1;
          send_gap = pick_gap(send_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and throttles with out_stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (drive_due_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing due: pwm %0d", pwm_count));
        end else begin
          drive_result_t want;
          want = drive_due_q.pop_front();
          if (pwm_count !== want.pwm)
            report_mismatch($sformatf("pwm_count %0d, want %0d", pwm_count, want.pwm));
          if (clockwise !== want.cw)
            report_mismatch($sformatf("clockwise %0b, want %0b", clockwise, want.cw));
          if (velocity_estimate !== want.vel)
            report_mismatch($sformatf("velocity_estimate %0d, want %0d",
                                      velocity_estimate, $signed(want.vel)));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        hold_left = pick_gap(hold_quiet);
        out_stall <= 1'b0;
      end
    end
  end

  // Called at a rising edge with the block idle; writes all seven registers.
  task automatic program_servo(input longint pg, input longint dg, input longint ig,
                               input longint sg, input logic [1:0] md, input longint fs,
                               input longint mn);
    logic [CFG_IDX_W-1:0] idx [7];
    logic [CFG_DATA_W-1:0] vals [7];
    idx = '{REG_PGAIN, REG_DGAIN, REG_IGAIN, REG_SOFTEN, REG_MODE, REG_FULLSCL, REG_MANUAL};
    vals = '{pg[23:0], dg[23:0], ig[23:0], sg[23:0], {22'd0, md}, {8'd0, fs[15:0]}, mn[23:0]};
    for (int k = 0; k < 7; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
      apply_reg(idx[k], vals[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_beat(input logic [15:0] cur, input logic [15:0] tgt,
                            input logic [31:0] adv);
    stamp_ms = stamp_ms + adv;
    beats_to_send.push_back('{cur, tgt, stamp_ms});
  endtask

  // Bearings mostly follow a slow track with the target close by half the time, so the
  // integral window and sensible velocities are reached often.
  task automatic queue_random_beat();
    logic [15:0] cur, tgt;
    logic [31:0] adv;
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) cur = 16'($urandom);
    else cur = 16'(track_bearing + $urandom_range(0, 4000) - 2000);
    track_bearing = cur;
    r = $urandom_range(0, 99);
    if (r < 50) tgt = 16'(cur + $urandom_range(0, 2000) - 1000);
    else if (r < 60) tgt = cur ^ 16'h8000;
    else tgt = 16'($urandom);
    r = $urandom_range(0, 99);
    if (r < 10) adv = 32'd0;
    else if (r < 85) adv = $urandom_range(1, 40);
    else if (r < 95) adv = $urandom_range(41, 100000);
    else adv = $urandom;
    queue_beat(cur, tgt, adv);
  endtask

  function automatic longint rand_gain(longint nominal, longint lowest);
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return longint'($urandom_range(32'(lowest), 32'(3 * nominal)));
    if (r < 85) return longint'($urandom_range(32'(lowest), 32'(GAIN_MAX)));
    return (r < 92) ? lowest : GAIN_MAX;
  endfunction

  // Wait until every beat is sent and answered, then settle, then align to an edge.
  task automatic wait_idle(input int settle);
    do @(negedge clk);
    while (beats_to_send.size() != 0 || in_valid || drive_due_q.size() != 0);
    repeat (settle) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    logic [1:0] md;
    longint fs;
    int r;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Direct drive: full scale both ways and both sides of the deadband, then idle mode.
    program_servo(163840, 14418, 19661, 65536, MODE_DIRECT, 65535, 65536);
    queue_beat(16'h0000, 16'h0000, 32'd0);
    queue_beat(16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    wait_idle(8);
    program_servo(163840, 14418, 19661, 65536, MODE_DIRECT, 65535, -65536);
    queue_beat(16'h1234, 16'hFEDC, 32'd0);
    wait_idle(8);
    program_servo(163840, 14418, 19661, 65536, MODE_DIRECT, 40000, 6553);
    queue_beat(16'h0001, 16'h0002, 32'd0);
    wait_idle(8);
    program_servo(163840, 14418, 19661, 65536, MODE_DIRECT, 40000, -6554);
    queue_beat(16'h0001, 16'h0002, 32'd0);
    wait_idle(8);
    program_servo(163840, 14418, 19661, 65536, MODE_IDLE, 40000, 30000);
    queue_beat(16'h5555, 16'hAAAA, 32'd5);
    wait_idle(8);

    // Position loop: half turn error, saturated velocity, integral window edges,
    // no elapsed time, and the timestamp wrapping.
    program_servo(163840, 14418, 19661, 65536, MODE_POSITION, 19000, 0);
    queue_beat(16'h0000, 16'h8000, 32'd1);
    queue_beat(16'h8000, 16'h0000, 32'd1);
    queue_beat(16'h4000, 16'h4000 + 16'd910, 32'd0);
    queue_beat(16'h4000, 16'h4000 - 16'd910, 32'd1);
    queue_beat(16'h4000, 16'h4000 + 16'd911, 32'd5);
    queue_beat(16'h4100, 16'h4100, 32'd3);
    queue_beat(16'h4200, 16'h41F0, 32'd7);
    queue_beat(16'h4300, 16'h4300, 32'hFFFFFFF0);
    queue_beat(16'h4310, 16'h4320, 32'h20);
    wait_idle(8);

    // Largest gains with the smallest softening drive the integral into both limits.
    program_servo(GAIN_MAX, GAIN_MAX, GAIN_MAX, 1, MODE_POSITION, 65535, 0);
    repeat (3) queue_beat(16'h1000, 16'h1000 + 16'd910, 32'd1);
    queue_beat(16'hFFFF, 16'h0000, 32'd1);
    repeat (2) queue_beat(16'hFFFF, 16'hFFFF - 16'd910, 32'd1);
    wait_idle(8);
    program_servo(0, 0, 0, GAIN_MAX, MODE_POSITION, 65535, 0);
    queue_beat(16'h7FFF, 16'h0000, 32'd2);
    queue_beat(16'h0000, 16'h0001, 32'd2);
    wait_idle(8);

    for (int ph = 0; ph < 9; ph++) begin
      r = $urandom_range(0, 99);
      md = (r < 65) ? MODE_POSITION : ((r < 85) ? MODE_DIRECT : MODE_IDLE);
      r = $urandom_range(0, 99);
      fs = (r < 10) ? 0 : ((r < 20) ? 65535 : longint'($urandom_range(0, 65535)));
      program_servo(rand_gain(163840, 0), rand_gain(14418, 0), rand_gain(19661, 0),
                    rand_gain(65536, 1), md, fs,
                    longint'($urandom_range(0, 131072)) - 65536);
      repeat ($urandom_range(40, 60)) queue_random_beat();
      wait_idle(8);
    end

    wait_idle(120);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/azps_pkg.sv
rtl/azps_div.sv
rtl/azimuth_position_servo.sv
tb/azimuth_position_servo_tb.sv
